[rtl/core/cgs_pkg.sv]
`default_nettype none
package cgs_pkg;

    localparam int IDX_W  = 12;
    localparam int NODE_W = 8;

    localparam logic [2:0] CMD_INDEX = 3'd0;
    localparam logic [2:0] CMD_VALUE = 3'd1;
    localparam logic [2:0] CMD_RHS   = 3'd2;
    localparam logic [2:0] CMD_SOL   = 3'd3;
    localparam logic [2:0] CMD_FIXED = 3'd4;
    localparam logic [2:0] CMD_RUN   = 3'd5;
    localparam logic [2:0] CMD_READ  = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [11:0]        addr;
        logic signed [31:0] data;
        logic               direction;
    } t_cmd;

    typedef struct packed {
        logic [8:0] matrix_size;
        logic [6:0] fixed_count;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } t_res;

endpackage
`default_nettype wire

[rtl/core/constrained_gauss_seidel_sweep_unit.sv]
// Store writes go from idle straight to the done state; solution reads pass a read state first.
// A sweep seeds the work store from the right-hand side, walks the stored entries of
// each row, and divides for each solved entry in the bit-serial divider.
// Throughput: one item at a time; the next item is taken once the sequencer is idle.
// Reset: synchronous, active low; clears the sequencer and the output valid flag,
// registers go to matrix_size 1 and fixed_count 0; stores are not cleared.
`default_nettype none
module constrained_gauss_seidel_sweep_unit import cgs_pkg::*; #(
    parameter int MAX_UNKNOWNS = 256,
    parameter int STORE_DEPTH  = 4096,
    parameter int MAX_FIXED    = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_cmd,
    input  wire logic [11:0]        i_addr,
    input  wire logic signed [31:0] i_data,
    input  wire logic               i_direction,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_read_value,
    output logic [1:0]              o_status,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_cmd w_cmd;
    t_cfg r_cfg;
    t_res w_res;
    t_res r_out;
    logic r_out_valid;
    logic w_idle, w_res_valid, w_ack, w_start;

    assign w_cmd   = '{cmd: i_cmd, addr: i_addr, data: i_data, direction: i_direction};
    assign w_start = i_in_valid && w_idle;
    assign w_ack   = w_res_valid && (!r_out_valid || !i_out_stall);

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(r_cfg.fixed_count) : 32'(r_cfg.matrix_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.matrix_size <= 9'd1;
            r_cfg.fixed_count <= 7'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_cfg.fixed_count <= pwdata[6:0];
            else          r_cfg.matrix_size <= pwdata[8:0];
        end
    end

    cgs_engine #(
        .MAX_UNKNOWNS (MAX_UNKNOWNS),
        .STORE_DEPTH  (STORE_DEPTH),
        .MAX_FIXED    (MAX_FIXED)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ack   (w_ack)
    );

    // hold the item until the far side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ack) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) r_out <= w_res;
    end

    assign o_in_stall   = !w_idle;
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out.read_value;
    assign o_status     = r_out.status;

endmodule
`default_nettype wire

[rtl/core/cgs_div.sv]
`default_nettype none
module cgs_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [63:0] r_q;
    logic [31:0] r_d;
    logic [32:0] w_sh;
    logic        w_ge;

    assign w_sh   = {r_rem[31:0], r_q[63]};
    assign w_ge   = (w_sh >= {1'b0, r_d});
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_d}) : w_sh;
            r_q   <= {r_q[62:0], w_ge};
        end
    end

endmodule
`default_nettype wire

[rtl/core/cgs_engine.sv]
`default_nettype none
module cgs_engine import cgs_pkg::*; #(
    parameter int MAX_UNKNOWNS = 256,
    parameter int STORE_DEPTH  = 4096,
    parameter int MAX_FIXED    = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_cmd i_cmd,
    input  wire t_cfg i_cfg,
    output logic      o_idle,
    output logic      o_res_valid,
    output t_res      o_res,
    input  wire logic i_res_ack
);

    localparam int SA = $clog2(STORE_DEPTH);
    localparam int UA = $clog2(MAX_UNKNOWNS);
    localparam int FA = (MAX_FIXED > 1) ? $clog2(MAX_FIXED) : 1;
    localparam int JW = $clog2(MAX_UNKNOWNS + 1);
    localparam int FW = $clog2(MAX_FIXED + 1);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_RDSOL     = 5'd1;
    localparam logic [4:0] S_DONE      = 5'd2;
    localparam logic [4:0] S_INIT_RD   = 5'd3;
    localparam logic [4:0] S_INIT_WR   = 5'd4;
    localparam logic [4:0] S_ROW_LO    = 5'd5;
    localparam logic [4:0] S_ROW_HI    = 5'd6;
    localparam logic [4:0] S_ROW_HW    = 5'd7;
    localparam logic [4:0] S_ROW_LD    = 5'd8;
    localparam logic [4:0] S_ROW_CHK   = 5'd9;
    localparam logic [4:0] S_ROW_COL   = 5'd10;
    localparam logic [4:0] S_ROW_MUL   = 5'd11;
    localparam logic [4:0] S_ROW_ACC   = 5'd12;
    localparam logic [4:0] S_P2        = 5'd13;
    localparam logic [4:0] S_FXINIT    = 5'd14;
    localparam logic [4:0] S_FIX       = 5'd15;
    localparam logic [4:0] S_FXLD      = 5'd16;
    localparam logic [4:0] S_SOLVE_RD  = 5'd17;
    localparam logic [4:0] S_SOLVE_CHK = 5'd18;
    localparam logic [4:0] S_SOLVE_DIV = 5'd19;

    function automatic logic in_sd(input logic [31:0] a);
        return a < STORE_DEPTH;
    endfunction

    function automatic logic in_un(input logic [31:0] a);
        return a < MAX_UNKNOWNS;
    endfunction

    function automatic logic in_fx(input logic [31:0] a);
        return a < MAX_FIXED;
    endfunction

    // stores
    logic [IDX_W-1:0]  idx_mem [0:STORE_DEPTH-1];
    logic [31:0]       val_mem [0:STORE_DEPTH-1];
    logic [31:0]       rhs_mem [0:MAX_UNKNOWNS-1];
    logic [31:0]       x_mem   [0:MAX_UNKNOWNS-1];
    logic [63:0]       w_mem   [0:MAX_UNKNOWNS-1];
    logic [NODE_W-1:0] fx_mem  [0:MAX_FIXED-1];

    logic [SA-1:0]     idx_ra, idx_wa, val_ra, val_wa;
    logic [UA-1:0]     rhs_ra, rhs_wa, x_ra, x_wa, w_ra, w_wa;
    logic [FA-1:0]     fx_ra, fx_wa;
    logic              idx_we, val_we, rhs_we, x_we, w_we, fx_we;
    logic [IDX_W-1:0]  idx_wd, idx_q;
    logic [31:0]       val_wd, val_q, rhs_wd, rhs_q, x_wd, x_q;
    logic [63:0]       w_wd, w_q;
    logic [NODE_W-1:0] fx_wd, fx_q;
    logic              idx_ok_c, idx_ok_q, val_ok_c, val_ok_q;

    always_ff @(posedge i_clk) begin
        if (idx_we) idx_mem[idx_wa] <= idx_wd;
        idx_q <= idx_mem[idx_ra];
    end
    always_ff @(posedge i_clk) begin
        if (val_we) val_mem[val_wa] <= val_wd;
        val_q <= val_mem[val_ra];
    end
    always_ff @(posedge i_clk) begin
        if (rhs_we) rhs_mem[rhs_wa] <= rhs_wd;
        rhs_q <= rhs_mem[rhs_ra];
    end
    always_ff @(posedge i_clk) begin
        if (x_we) x_mem[x_wa] <= x_wd;
        x_q <= x_mem[x_ra];
    end
    always_ff @(posedge i_clk) begin
        if (w_we) w_mem[w_wa] <= w_wd;
        w_q <= w_mem[w_ra];
    end
    always_ff @(posedge i_clk) begin
        if (fx_we) fx_mem[fx_wa] <= fx_wd;
        fx_q <= fx_mem[fx_ra];
    end
    always_ff @(posedge i_clk) begin
        idx_ok_q <= idx_ok_c;
        val_ok_q <= val_ok_c;
    end

    // sequencer state
    logic [4:0]        r_st, n_st;
    logic              r_ev_range, n_ev_range, r_ev_zero, n_ev_zero, r_ev_sat, n_ev_sat;
    logic              r_sweep, n_sweep;
    logic [31:0]       r_rv, n_rv;
    logic [1:0]        r_stat, n_stat;
    logic              r_fwd, n_fwd, r_gather, n_gather, r_pass2, n_pass2;
    logic              r_have, n_have, r_neg, n_neg;
    logic [JW-1:0]     r_j, n_j, r_n, n_n;
    logic [FW-1:0]     r_t, n_t, r_fc, n_fc;
    logic [NODE_W-1:0] r_ft, n_ft;
    logic [IDX_W-1:0]  r_p, n_p, r_hi, n_hi, r_c, n_c;
    logic signed [63:0] r_acc, n_acc, r_prod, n_prod;
    logic signed [31:0] r_xj, n_xj;

    // shared datapath
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [64:0] sub_d;
    logic signed [63:0] sub_r;
    logic               sub_sat;
    logic [IDX_W-1:0]   col_c;
    logic signed [31:0] diag;
    logic               div_start, div_done;
    logic [63:0]        div_dvd, div_quot;
    logic [31:0]        div_dvs;
    logic [JW-1:0]      n_lim;
    logic [FW-1:0]      fc_lim;
    logic               is_fixed;

    assign mul_a = val_ok_q ? $signed(val_q) : 32'sd0;
    assign mul_b = r_gather ? $signed(x_q) : r_xj;
    assign mul_p = mul_a * mul_b;
    assign sub_d = {r_acc[63], r_acc} - {r_prod[63], r_prod};
    assign sub_sat = sub_d[64] != sub_d[63];
    assign sub_r = !sub_sat ? sub_d[63:0]
                 : (sub_d[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});
    assign col_c = idx_ok_q ? idx_q : '0;
    assign diag  = val_ok_q ? $signed(val_q) : 32'sd0;
    assign n_lim = (32'(i_cfg.matrix_size) > MAX_UNKNOWNS) ? JW'(MAX_UNKNOWNS)
                                                            : JW'(i_cfg.matrix_size);
    assign fc_lim = (32'(i_cfg.fixed_count) > MAX_FIXED) ? FW'(MAX_FIXED)
                                                          : FW'(i_cfg.fixed_count);
    assign is_fixed = r_have && (32'(r_j) == 32'(r_ft));

    cgs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_st = r_st;  n_ev_range = r_ev_range;  n_ev_zero = r_ev_zero;  n_ev_sat = r_ev_sat;
        n_sweep = r_sweep;  n_rv = r_rv;  n_stat = r_stat;  n_fwd = r_fwd;
        n_gather = r_gather;  n_pass2 = r_pass2;  n_have = r_have;  n_neg = r_neg;
        n_j = r_j;  n_n = r_n;  n_t = r_t;  n_fc = r_fc;  n_ft = r_ft;
        n_p = r_p;  n_hi = r_hi;  n_c = r_c;  n_acc = r_acc;  n_prod = r_prod;  n_xj = r_xj;
        idx_ra = '0;  val_ra = '0;  rhs_ra = '0;  x_ra = '0;  w_ra = '0;  fx_ra = '0;
        idx_ok_c = 1'b1;  val_ok_c = 1'b1;
        idx_we = 1'b0;  val_we = 1'b0;  rhs_we = 1'b0;  x_we = 1'b0;  w_we = 1'b0;
        fx_we = 1'b0;
        idx_wa = SA'(i_cmd.addr);  val_wa = SA'(i_cmd.addr);  rhs_wa = UA'(i_cmd.addr);
        x_wa = UA'(i_cmd.addr);  w_wa = UA'(r_j);  fx_wa = FA'(i_cmd.addr);
        idx_wd = i_cmd.data[IDX_W-1:0];  val_wd = i_cmd.data;  rhs_wd = i_cmd.data;
        x_wd = i_cmd.data;  w_wd = r_acc;  fx_wd = i_cmd.data[NODE_W-1:0];
        div_start = 1'b0;  div_dvd = '0;  div_dvs = '0;
        o_res_valid = 1'b0;

        case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    n_sweep = 1'b0;
                    n_rv    = '0;
                    n_stat  = ST_OK;
                    n_st    = S_DONE;
                    case (i_cmd.cmd)
                        CMD_INDEX: begin
                            if (in_sd(32'(i_cmd.addr))) idx_we = 1'b1;
                            else n_stat = ST_RANGE;
                        end
                        CMD_VALUE: begin
                            if (in_sd(32'(i_cmd.addr))) val_we = 1'b1;
                            else n_stat = ST_RANGE;
                        end
                        CMD_RHS: begin
                            if (in_un(32'(i_cmd.addr))) rhs_we = 1'b1;
                            else n_stat = ST_RANGE;
                        end
                        CMD_SOL: begin
                            if (in_un(32'(i_cmd.addr))) x_we = 1'b1;
                            else n_stat = ST_RANGE;
                        end
                        CMD_FIXED: begin
                            if (in_fx(32'(i_cmd.addr))) fx_we = 1'b1;
                            else n_stat = ST_RANGE;
                        end
                        CMD_READ: begin
                            if (in_un(32'(i_cmd.addr))) begin
                                x_ra = UA'(i_cmd.addr);
                                n_st = S_RDSOL;
                            end else begin
                                n_stat = ST_RANGE;
                            end
                        end
                        CMD_RUN: begin
                            n_sweep    = 1'b1;
                            n_ev_range = 1'b0;
                            n_ev_zero  = 1'b0;
                            n_ev_sat   = 1'b0;
                            n_fwd      = i_cmd.direction;
                            n_n        = n_lim;
                            n_fc       = fc_lim;
                            n_pass2    = 1'b0;
                            n_j        = '0;
                            if (n_lim != '0) n_st = S_INIT_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDSOL: begin
                n_rv = x_q;
                n_st = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ack) n_st = S_IDLE;
            end
            // work = rhs scaled to Q32.32
            S_INIT_RD: begin
                rhs_ra = UA'(r_j);
                n_st   = S_INIT_WR;
            end
            S_INIT_WR: begin
                w_we = 1'b1;
                w_wd = {{16{rhs_q[31]}}, rhs_q, 16'd0};
                if (32'(r_j) + 32'd1 == 32'(r_n)) begin
                    n_j      = '0;
                    n_gather = r_fwd;
                    n_st     = S_ROW_LO;
                end else begin
                    n_j  = r_j + 1'b1;
                    n_st = S_INIT_RD;
                end
            end
            S_ROW_LO: begin
                idx_ra   = SA'(r_j);
                idx_ok_c = in_sd(32'(r_j));
                if (!idx_ok_c) n_ev_range = 1'b1;
                n_st = S_ROW_HI;
            end
            S_ROW_HI: begin
                n_p      = idx_ok_q ? idx_q : '0;
                idx_ra   = SA'(32'(r_j) + 32'd1);
                idx_ok_c = in_sd(32'(r_j) + 32'd1);
                if (!idx_ok_c) n_ev_range = 1'b1;
                n_st = S_ROW_HW;
            end
            S_ROW_HW: begin
                n_hi = idx_ok_q ? idx_q : '0;
                x_ra = UA'(r_j);
                w_ra = UA'(r_j);
                n_st = S_ROW_LD;
            end
            S_ROW_LD: begin
                if (r_gather) n_acc = $signed(w_q);
                n_xj = $signed(x_q);
                n_st = S_ROW_CHK;
            end
            S_ROW_CHK: begin
                if (r_p < r_hi) begin
                    idx_ra   = SA'(r_p);
                    idx_ok_c = in_sd(32'(r_p));
                    if (!idx_ok_c) n_ev_range = 1'b1;
                    n_st = S_ROW_COL;
                end else begin
                    if (r_gather) w_we = 1'b1;
                    if (!r_pass2) begin
                        if (32'(r_j) + 32'd1 == 32'(r_n)) begin
                            n_st = S_P2;
                        end else begin
                            n_j  = r_j + 1'b1;
                            n_st = S_ROW_LO;
                        end
                    end else if (r_fwd) begin
                        if (32'(r_j) + 32'd1 == 32'(r_n)) begin
                            n_st = S_DONE;
                        end else begin
                            n_j  = r_j + 1'b1;
                            n_st = S_FIX;
                        end
                    end else begin
                        n_st = S_SOLVE_RD;
                    end
                end
            end
            S_ROW_COL: begin
                if (32'(col_c) >= 32'(r_n)) begin
                    // column outside the matrix: skip entry
                    n_ev_range = 1'b1;
                    n_p  = r_p + 1'b1;
                    n_st = S_ROW_CHK;
                end else begin
                    val_ra   = SA'(r_p);
                    val_ok_c = in_sd(32'(r_p));
                    if (!val_ok_c) n_ev_range = 1'b1;
                    x_ra = UA'(col_c);
                    w_ra = UA'(col_c);
                    n_c  = col_c;
                    n_st = S_ROW_MUL;
                end
            end
            S_ROW_MUL: begin
                n_prod = mul_p;
                if (!r_gather) n_acc = $signed(w_q);
                n_st = S_ROW_ACC;
            end
            S_ROW_ACC: begin
                if (sub_sat) n_ev_sat = 1'b1;
                if (r_gather) begin
                    n_acc = sub_r;
                end else begin
                    w_we = 1'b1;
                    w_wa = UA'(r_c);
                    w_wd = sub_r;
                end
                n_p  = r_p + 1'b1;
                n_st = S_ROW_CHK;
            end
            S_P2: begin
                n_pass2 = 1'b1;
                n_have  = (r_fc != '0);
                fx_ra   = r_fwd ? '0 : FA'(r_fc - 1'b1);
                n_t     = r_fwd ? FW'(1) : FW'(r_fc - 1'b1);
                n_st    = S_FXINIT;
            end
            S_FXINIT: begin
                n_ft = fx_q;
                n_j  = r_fwd ? '0 : JW'(r_n - 1'b1);
                n_st = S_FIX;
            end
            S_FIX: begin
                if (!is_fixed) begin
                    if (r_fwd) begin
                        n_st = S_SOLVE_RD;
                    end else begin
                        n_gather = 1'b1;
                        n_st     = S_ROW_LO;
                    end
                end else if (r_fwd) begin
                    if (r_t < r_fc) begin
                        fx_ra = FA'(r_t);
                        n_t   = r_t + 1'b1;
                        n_st  = S_FXLD;
                    end else begin
                        n_gather = 1'b0;
                        n_st     = S_ROW_LO;
                    end
                end else if (r_t != '0) begin
                    fx_ra = FA'(r_t - 1'b1);
                    n_t   = r_t - 1'b1;
                    n_st  = S_FXLD;
                end else if (r_j == '0) begin
                    n_st = S_DONE;
                end else begin
                    n_j  = r_j - 1'b1;
                    n_st = S_FIX;
                end
            end
            S_FXLD: begin
                n_ft = fx_q;
                if (r_fwd) begin
                    n_gather = 1'b0;
                    n_st     = S_ROW_LO;
                end else if (r_j == '0) begin
                    n_st = S_DONE;
                end else begin
                    n_j  = r_j - 1'b1;
                    n_st = S_FIX;
                end
            end
            S_SOLVE_RD: begin
                val_ra   = SA'(r_j);
                val_ok_c = in_sd(32'(r_j));
                if (!val_ok_c) n_ev_range = 1'b1;
                w_ra = UA'(r_j);
                n_st = S_SOLVE_CHK;
            end
            S_SOLVE_CHK: begin
                if (diag == 32'sd0) begin
                    // leave this entry as it is
                    n_ev_zero = 1'b1;
                    if (r_fwd) begin
                        n_gather = 1'b0;
                        n_st     = S_ROW_LO;
                    end else if (r_j == '0) begin
                        n_st = S_DONE;
                    end else begin
                        n_j  = r_j - 1'b1;
                        n_st = S_FIX;
                    end
                end else begin
                    n_neg     = w_q[63] ^ diag[31];
                    div_start = 1'b1;
                    div_dvd   = w_q[63] ? (64'd0 - w_q) : w_q;
                    div_dvs   = diag[31] ? (32'd0 - 32'(diag)) : 32'(diag);
                    n_st      = S_SOLVE_DIV;
                end
            end
            S_SOLVE_DIV: begin
                if (div_done) begin
                    x_we = 1'b1;
                    x_wa = UA'(r_j);
                    if (!r_neg && div_quot > 64'h7FFF_FFFF) begin
                        n_ev_sat = 1'b1;
                        x_wd     = 32'h7FFF_FFFF;
                    end else if (r_neg && div_quot > 64'h8000_0000) begin
                        n_ev_sat = 1'b1;
                        x_wd     = 32'h8000_0000;
                    end else begin
                        x_wd = r_neg ? (32'd0 - div_quot[31:0]) : div_quot[31:0];
                    end
                    if (r_fwd) begin
                        n_gather = 1'b0;
                        n_st     = S_ROW_LO;
                    end else if (r_j == '0) begin
                        n_st = S_DONE;
                    end else begin
                        n_j  = r_j - 1'b1;
                        n_st = S_FIX;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_range <= n_ev_range;  r_ev_zero <= n_ev_zero;  r_ev_sat <= n_ev_sat;
        r_sweep <= n_sweep;  r_rv <= n_rv;  r_stat <= n_stat;  r_fwd <= n_fwd;
        r_gather <= n_gather;  r_pass2 <= n_pass2;  r_have <= n_have;  r_neg <= n_neg;
        r_j <= n_j;  r_n <= n_n;  r_t <= n_t;  r_fc <= n_fc;  r_ft <= n_ft;
        r_p <= n_p;  r_hi <= n_hi;  r_c <= n_c;  r_acc <= n_acc;  r_prod <= n_prod;
        r_xj <= n_xj;
    end

    assign o_idle = (r_st == S_IDLE);
    assign o_res.read_value = $signed(r_rv);
    assign o_res.status = !r_sweep  ? r_stat
                        : r_ev_zero ? ST_ZERO
                        : r_ev_sat  ? ST_SAT
                        : r_ev_range ? ST_RANGE : ST_OK;

endmodule
`default_nettype wire

[rtl/core/cgs_checker.sv]
`default_nettype none
module cgs_checker import cgs_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic signed [31:0] o_read_value,
    input wire logic [1:0]         o_status
);

    // an accepted item keeps the unit busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("unit took a second item right after the first");

    a_value_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_read_value != 32'sd0)) |-> (o_status == ST_OK))
        else $error("nonzero read value with error status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_read_value) && $stable(o_status)))
        else $error("stalled output item changed");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("unit not idle after reset");

endmodule

bind constrained_gauss_seidel_sweep_unit cgs_checker u_cgs_checker (.*);
`default_nettype wire
